// ----- sv/cwsc_pkg.sv -----
// Shared types, cost tables and field widths for the wait-state cost block.
package cwsc_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned WC_W     = 16;
    localparam int unsigned COST_W   = 6;
    localparam int unsigned ENTRY_W  = 4;
    localparam int unsigned REGION_W = 8;

    typedef enum logic [1:0] {
        ACT_READ16  = 2'd0,
        ACT_READ32  = 2'd1,
        ACT_FETCH16 = 2'd2,
        ACT_FETCH32 = 2'd3
    } t_action;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [COST_W-1:0]  t_cost;

    // First-access and SRAM select table: {4, 3, 2, 8}
    localparam t_entry FIRST_COST [4] = '{4'd4, 4'd3, 4'd2, 4'd8};
    localparam t_entry SRAM_COST  [4] = '{4'd4, 4'd3, 4'd2, 4'd8};
    // Sequential cost when the window's select bit is clear; set gives 1
    localparam t_entry SEQ_SLOW   [3] = '{4'd2, 4'd4, 4'd8};
    localparam t_entry SEQ_FAST       = 4'd1;

    localparam t_entry BOUNDARY_PENALTY = 4'd2;

    // Regions of the address map (address bits 31:24)
    localparam logic [REGION_W-1:0] REGION_ROM_LO  = 8'h08;
    localparam logic [REGION_W-1:0] REGION_ROM_HI  = 8'h0D;
    localparam logic [REGION_W-1:0] REGION_SRAM_LO = 8'h0E;
    localparam logic [REGION_W-1:0] REGION_SRAM_HI = 8'h0F;

    // Bits of the aligned address that must be zero for a 128 KiB boundary
    localparam int unsigned BOUND_HI = 16;
    localparam int unsigned BOUND_LO = 2;

endpackage

// ----- sv/cwsc_access_if.sv -----
// Handshake channel that carries one bus access to be priced.
interface cwsc_access_if;
    import cwsc_pkg::*;

    logic                valid;
    logic                ready;
    t_action             action;
    logic [ADDR_W-1:0]   address;
    logic                sequential;

    modport source (output valid, output action, output address, output sequential,
                    input ready);
    modport sink   (input valid, input action, input address, input sequential,
                    output ready);
endinterface

// ----- sv/cwsc_cost_if.sv -----
// Handshake channel that carries the wait-cycle count of one access.
interface cwsc_cost_if;
    import cwsc_pkg::*;

    logic   valid;
    logic   ready;
    t_cost  extra_cycles;

    modport source (output valid, output extra_cycles, input ready);
    modport sink   (input valid, input extra_cycles, output ready);
endinterface

// ----- sv/cwsc_price.sv -----
// Combinational pricing of one access against the wait-control word.
module cwsc_price (
    input  logic [cwsc_pkg::WC_W-1:0]   i_wait_control,
    input  cwsc_pkg::t_action           i_action,
    input  logic [cwsc_pkg::ADDR_W-1:0] i_address,
    input  logic                        i_sequential,
    output cwsc_pkg::t_cost             o_extra_cycles
);
    import cwsc_pkg::*;

    logic [REGION_W-1:0] region;
    logic                is_fetch;
    logic                wide;
    logic                seq_eff;
    logic                in_rom;
    logic                in_sram;
    logic [1:0]          window;
    logic [1:0]          first_sel;
    logic                seq_sel;
    t_entry              first_cost;
    t_entry              seq_cost;
    t_entry              half_cost;
    t_entry              sram_entry;
    logic                on_boundary;
    t_cost               rom_total;
    t_cost               sram_total;

    always_comb begin
        region   = i_address[ADDR_W-1 -: REGION_W];
        is_fetch = (i_action == ACT_FETCH16) || (i_action == ACT_FETCH32);
        wide     = (i_action == ACT_READ32) || (i_action == ACT_FETCH32);
        // reads are always first accesses
        seq_eff  = is_fetch && i_sequential;
        in_rom   = (region >= REGION_ROM_LO) && (region <= REGION_ROM_HI);
        in_sram  = (region == REGION_SRAM_LO) || (region == REGION_SRAM_HI);
        // windows 0x08/09, 0x0A/0B, 0x0C/0D map to 0, 1, 2
        window   = region[2:1];

        case (window)
            2'd0: begin
                first_sel = i_wait_control[3:2];
                seq_sel   = i_wait_control[4];
            end
            2'd1: begin
                first_sel = i_wait_control[6:5];
                seq_sel   = i_wait_control[7];
            end
            2'd2: begin
                first_sel = i_wait_control[9:8];
                seq_sel   = i_wait_control[10];
            end
            default: begin
                first_sel = 2'd0;
                seq_sel   = 1'b0;
            end
        endcase

        first_cost = FIRST_COST[first_sel];
        if (seq_sel) begin
            seq_cost = SEQ_FAST;
        end else if (window == 2'd3) begin
            seq_cost = '0;
        end else begin
            seq_cost = SEQ_SLOW[window];
        end
        half_cost = seq_eff ? seq_cost : first_cost;

        on_boundary = (i_address[BOUND_HI:BOUND_LO] == '0);
        rom_total   = COST_W'(half_cost);
        if (wide) begin
            rom_total = COST_W'(half_cost) + COST_W'(seq_cost);
            if (on_boundary && !seq_eff) begin
                rom_total = rom_total + COST_W'(BOUNDARY_PENALTY);
            end
        end

        sram_entry = in_sram ? SRAM_COST[i_wait_control[1:0]] : '0;
        // 32-bit SRAM access costs four times the entry
        sram_total = wide ? {sram_entry, 2'b00} : COST_W'(sram_entry);

        o_extra_cycles = in_rom ? rom_total : sram_total;
    end

endmodule

// ----- sv/cartridge_wait_state_cost.sv -----
// Top level of the wait-state cost block: input register, pricing, result register.
// Prices one bus access per clock while o_cost is not stalled: the edge that accepts an
// item on i_access loads the input register, and its wait-cycle count is loaded from
// there into the result register, which drives o_cost, once that register is free or
// being emptied. A new item may be taken every cycle while results flow. A stalled
// o_cost holds the result register, and one more item can still be taken into the input
// register. The count is computed from the wait-control word held in the block; write it
// with i_cfg_we only while no item is in flight.
module cartridge_wait_state_cost (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cwsc_pkg::WC_W-1:0]  i_cfg_wdata,
    cwsc_access_if.sink                i_access,
    cwsc_cost_if.source                o_cost
);
    import cwsc_pkg::*;

    logic [WC_W-1:0]   r_wait_control;
    logic              r_in_valid;
    t_action           r_action;
    logic [ADDR_W-1:0] r_address;
    logic              r_sequential;
    logic              r_out_valid;
    t_cost             r_extra_cycles;

    logic              n_in_valid;
    logic              n_out_valid;
    logic              out_load;
    logic              in_load;
    t_cost             price;

    cwsc_price u_price (
        .i_wait_control (r_wait_control),
        .i_action       (r_action),
        .i_address      (r_address),
        .i_sequential   (r_sequential),
        .o_extra_cycles (price)
    );

    always_comb begin
        // advance the input stage when the result register is free or being emptied
        out_load         = r_in_valid && (!r_out_valid || o_cost.ready);
        i_access.ready   = !r_in_valid || out_load;
        in_load          = i_access.valid && i_access.ready;
        n_in_valid       = in_load || (r_in_valid && !out_load);
        n_out_valid      = out_load || (r_out_valid && !o_cost.ready);
        o_cost.valid        = r_out_valid;
        o_cost.extra_cycles = r_extra_cycles;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_control <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wait_control <= i_cfg_wdata;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_action     <= i_access.action;
            r_address    <= i_access.address;
            r_sequential <= i_access.sequential;
        end
        if (out_load) begin
            r_extra_cycles <= price;
        end
    end

endmodule
